/* hw/rtl/lcvm_pkg.sv */
package lcvm_pkg;

  // Configuration register file: eight registers, one 32-bit word each.
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_WIN_X_MIN  = 3'd0,
    REG_WIN_Y_MIN  = 3'd1,
    REG_WIN_X_MAX  = 3'd2,
    REG_WIN_Y_MAX  = 3'd3,
    REG_VIEW_X_MIN = 3'd4,
    REG_VIEW_Y_MIN = 3'd5,
    REG_VIEW_X_MAX = 3'd6,
    REG_VIEW_Y_MAX = 3'd7
  } cfg_reg_e;

  // Reset values, truncated to the coordinate width where they are used.
  localparam logic [31:0] CFG_RESET [NUM_REGS] = '{
    32'd800, 32'd800, 32'd1600, 32'd1600,
    32'd3200, 32'd3200, 32'd4800, 32'd4800
  };

  // Handshake control that moves between the stages of a divider chain.
  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctrl_t;

endpackage

/* hw/rtl/lcvm_div_cell.sv */
// One restoring division step for several independent lanes. The quotient
// bit is shifted into the low end of the accumulator while the dividend bits
// leave it at the top.
module lcvm_div_cell #(
  parameter int unsigned LANES = 4,
  parameter int unsigned DW    = 17,
  parameter int unsigned QB    = 18,
  parameter int unsigned SW    = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcvm_pkg::stage_ctrl_t         ctrl_i,
  input  logic [LANES-1:0][DW-1:0]      rem_i,
  input  logic [LANES-1:0][DW-1:0]      den_i,
  input  logic [LANES-1:0][QB-1:0]      acc_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          valid_o,
  output logic [LANES-1:0][DW-1:0]      rem_o,
  output logic [LANES-1:0][DW-1:0]      den_o,
  output logic [LANES-1:0][QB-1:0]      acc_o,
  output logic [SW-1:0]                 side_o
);

  logic                     valid_q;
  logic [LANES-1:0][DW-1:0] rem_d, rem_q, den_q;
  logic [LANES-1:0][QB-1:0] acc_d, acc_q;
  logic [SW-1:0]            side_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [DW:0] trial;
    logic        fits;
    assign trial = {rem_i[l], acc_i[l][QB-1]};
    assign fits  = trial >= {1'b0, den_i[l]};
    assign rem_d[l] = fits ? DW'(trial - {1'b0, den_i[l]}) : trial[DW-1:0];
    assign acc_d[l] = {acc_i[l][QB-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.en) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      rem_q  <= rem_d;
      acc_q  <= acc_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule

/* hw/rtl/lcvm_div_chain.sv */
// A row of QB division cells; each one resolves one quotient bit per lane.
module lcvm_div_chain #(
  parameter int unsigned LANES = 4,
  parameter int unsigned DW    = 17,
  parameter int unsigned QB    = 18,
  parameter int unsigned SW    = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [LANES-1:0][DW-1:0] rem_i,
  input  logic [LANES-1:0][DW-1:0] den_i,
  input  logic [LANES-1:0][QB-1:0] acc_i,
  input  logic [SW-1:0]            side_i,
  output logic                     valid_o,
  output logic [LANES-1:0][QB-1:0] acc_o,
  output logic [SW-1:0]            side_o
);

  logic [QB:0]                     v;
  logic [QB:0][LANES-1:0][DW-1:0]  rem;
  logic [QB:0][LANES-1:0][DW-1:0]  den;
  logic [QB:0][LANES-1:0][QB-1:0]  acc;
  logic [QB:0][SW-1:0]             side;

  assign v[0]    = valid_i;
  assign rem[0]  = rem_i;
  assign den[0]  = den_i;
  assign acc[0]  = acc_i;
  assign side[0] = side_i;

  for (genvar g = 0; g < QB; g++) begin : g_cell
    lcvm_pkg::stage_ctrl_t ctrl;
    assign ctrl.en    = en_i;
    assign ctrl.valid = v[g];

    lcvm_div_cell #(
      .LANES(LANES),
      .DW   (DW),
      .QB   (QB),
      .SW   (SW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .rem_i  (rem[g]),
      .den_i  (den[g]),
      .acc_i  (acc[g]),
      .side_i (side[g]),
      .valid_o(v[g+1]),
      .rem_o  (rem[g+1]),
      .den_o  (den[g+1]),
      .acc_o  (acc[g+1]),
      .side_o (side[g+1])
    );
  end

  assign valid_o = v[QB];
  assign acc_o   = acc[QB];
  assign side_o  = side[QB];

endmodule

/* hw/rtl/line_clip_viewport_map_unit.sv */
// Stages: E0, edge divider, T, M1, M2, M3, mapping divider, output register.
// Throughput: one segment per cycle while the skid register is empty; the two
// divider cell rows and the multiplier stages are fully pipelined and all
// advance together.
// Reset clears the stage valid bits and loads the window and viewport
// registers with their reset values; no clearing pass is needed.
module line_clip_viewport_map_unit #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [lcvm_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [lcvm_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [lcvm_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready,
  // Segment requests.
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]          start_x_i,
  input  logic signed [COORD_WIDTH-1:0]          start_y_i,
  input  logic signed [COORD_WIDTH-1:0]          end_x_i,
  input  logic signed [COORD_WIDTH-1:0]          end_y_i,
  // Results.
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   visible_o,
  output logic signed [COORD_WIDTH-1:0]          out_start_x_o,
  output logic signed [COORD_WIDTH-1:0]          out_start_y_o,
  output logic signed [COORD_WIDTH-1:0]          out_end_x_o,
  output logic signed [COORD_WIDTH-1:0]          out_end_y_o
);

  // ---------------------------------------------------------------------
  // Widths. Differences of two coordinates need one extra bit. The edge
  // parameter t is kept as a clamped magnitude: anything above one plus one
  // LSB behaves the same in the entry and exit comparisons, so the edge
  // divider only resolves TF+2 quotient bits. The mapping quotient is
  // clamped above 2^(CW+1), which always saturates the result.
  // ---------------------------------------------------------------------
  localparam int unsigned CW      = COORD_WIDTH;
  localparam int unsigned TF      = T_FRAC_BITS;
  localparam int unsigned DIFF_W  = CW + 1;
  localparam int unsigned EDGE_QB = TF + 2;
  localparam int unsigned TW      = TF + 2;
  localparam int unsigned TE_W    = TF + 1;
  localparam int unsigned PROD_W  = TE_W + DIFF_W;
  localparam int unsigned NUM_W   = 2 * DIFF_W;
  localparam int unsigned MAP_QB  = CW + 1;
  localparam int unsigned LANES   = 4;

  localparam logic [TW-1:0] T_ONE = TW'(1) << TF;
  localparam logic [TW-1:0] T_SAT = T_ONE + TW'(1);

  localparam logic signed [CW+2:0] V_MAX = {4'b0000, {(CW-1){1'b1}}};
  localparam logic signed [CW+2:0] V_MIN = {4'b1111, {(CW-1){1'b0}}};

  typedef logic signed [CW-1:0]     coord_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [DIFF_W-1:0]        umag_t;

  typedef struct packed {
    coord_t     x0;
    coord_t     y0;
    diff_t      dx;
    diff_t      dy;
    logic [3:0] qneg;
    logic [3:0] pneg;
    logic [3:0] pzero;
    logic [3:0] sat;
  } edge_side_t;

  typedef struct packed {
    logic       visible;
    logic [3:0] neg;
    logic [3:0] sat;
  } map_side_t;

  typedef struct packed {
    logic   visible;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } result_t;

  function automatic diff_t widen(input coord_t a);
    return {a[CW-1], a};
  endfunction

  function automatic umag_t magn(input diff_t a);
    return a[DIFF_W-1] ? umag_t'(-a) : umag_t'(a);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase; reads are
  // sign-extended to the bus width.
  // ---------------------------------------------------------------------
  coord_t     cfg_q [lcvm_pkg::NUM_REGS];
  logic [2:0] reg_idx;

  assign reg_idx = paddr[lcvm_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = lcvm_pkg::APB_DATA_W'(cfg_q[reg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lcvm_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= lcvm_pkg::CFG_RESET[i][CW-1:0];
      end
    end else if (psel && penable && pwrite && pready) begin
      cfg_q[reg_idx] <= pwdata[CW-1:0];
    end
  end

  coord_t win_x_min, win_y_min, win_x_max, win_y_max;
  coord_t view_x_min, view_y_min, view_x_max, view_y_max;

  assign win_x_min  = cfg_q[lcvm_pkg::REG_WIN_X_MIN];
  assign win_y_min  = cfg_q[lcvm_pkg::REG_WIN_Y_MIN];
  assign win_x_max  = cfg_q[lcvm_pkg::REG_WIN_X_MAX];
  assign win_y_max  = cfg_q[lcvm_pkg::REG_WIN_Y_MAX];
  assign view_x_min = cfg_q[lcvm_pkg::REG_VIEW_X_MIN];
  assign view_y_min = cfg_q[lcvm_pkg::REG_VIEW_Y_MIN];
  assign view_x_max = cfg_q[lcvm_pkg::REG_VIEW_X_MAX];
  assign view_y_max = cfg_q[lcvm_pkg::REG_VIEW_Y_MAX];

  // Window and viewport spans per axis. Lanes 0 and 2 are x, 1 and 3 are y.
  diff_t win_dx, win_dy, view_dx, view_dy;
  assign win_dx  = widen(win_x_max) - widen(win_x_min);
  assign win_dy  = widen(win_y_max) - widen(win_y_min);
  assign view_dx = widen(view_x_max) - widen(view_x_min);
  assign view_dy = widen(view_y_max) - widen(view_y_min);

  // ---------------------------------------------------------------------
  // Flow control. Every stage ahead of the output register advances on one
  // common enable. The output register is backed by a skid register, so the
  // pipeline keeps taking requests while a finished result waits; it only
  // stops when both hold a result.
  // ---------------------------------------------------------------------
  logic    en;
  logic    out_v_q, skid_v_q;
  result_t out_q, skid_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // ---------------------------------------------------------------------
  // Stage E0: register the segment with its deltas and the edge
  // distances q (left, right, bottom, top).
  // ---------------------------------------------------------------------
  logic  e0_v_q;
  coord_t e0_x0_q, e0_y0_q;
  diff_t e0_dx_q, e0_dy_q;
  diff_t e0_qd_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_v_q <= 1'b0;
    end else if (en) begin
      e0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_x0_q    <= start_x_i;
      e0_y0_q    <= start_y_i;
      e0_dx_q    <= widen(end_x_i) - widen(start_x_i);
      e0_dy_q    <= widen(end_y_i) - widen(start_y_i);
      e0_qd_q[0] <= widen(start_x_i) - widen(win_x_min);
      e0_qd_q[1] <= widen(win_x_max) - widen(start_x_i);
      e0_qd_q[2] <= widen(start_y_i) - widen(win_y_min);
      e0_qd_q[3] <= widen(win_y_max) - widen(start_y_i);
    end
  end

  // Edge divider setup: t = q * 2^TF / p on magnitudes. The dividend's top
  // bits above the resolved quotient width form the first remainder; if they
  // already reach the divisor the quotient is past the clamp.
  diff_t                          e0_pd [LANES];
  logic [LANES-1:0][DIFF_W-1:0]   ediv_rem, ediv_den;
  logic [LANES-1:0][EDGE_QB-1:0]  ediv_acc;
  edge_side_t                     edge_side_in, edge_side_out;
  logic                           ediv_v;
  logic [LANES-1:0][EDGE_QB-1:0]  ediv_q;

  assign e0_pd[0] = -e0_dx_q;
  assign e0_pd[1] = e0_dx_q;
  assign e0_pd[2] = -e0_dy_q;
  assign e0_pd[3] = e0_dy_q;

  for (genvar l = 0; l < LANES; l++) begin : g_edge_setup
    umag_t qm, pm;
    assign qm = magn(e0_qd_q[l]);
    assign pm = magn(e0_pd[l]);
    assign ediv_rem[l] = qm >> 2;
    assign ediv_den[l] = pm;
    assign ediv_acc[l] = {qm[1:0], {TF{1'b0}}};
    assign edge_side_in.qneg[l]  = e0_qd_q[l][DIFF_W-1];
    assign edge_side_in.pneg[l]  = e0_pd[l][DIFF_W-1];
    assign edge_side_in.pzero[l] = (e0_pd[l] == '0);
    assign edge_side_in.sat[l]   = (qm >> 2) >= pm;
  end

  assign edge_side_in.x0 = e0_x0_q;
  assign edge_side_in.y0 = e0_y0_q;
  assign edge_side_in.dx = e0_dx_q;
  assign edge_side_in.dy = e0_dy_q;

  lcvm_div_chain #(
    .LANES(LANES),
    .DW   (DIFF_W),
    .QB   (EDGE_QB),
    .SW   ($bits(edge_side_t))
  ) u_edge_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(e0_v_q),
    .rem_i  (ediv_rem),
    .den_i  (ediv_den),
    .acc_i  (ediv_acc),
    .side_i (edge_side_in),
    .valid_o(ediv_v),
    .acc_o  (ediv_q),
    .side_o (edge_side_out)
  );

  // ---------------------------------------------------------------------
  // Stage T: signed, clamped t per edge, then entry te = max(0, entries)
  // and exit tl = min(1, exits). An edge parallel to the window with q < 0
  // rejects the segment outright. The segment is visible when te <= tl,
  // which gives the same answer as testing the edges one after another.
  // ---------------------------------------------------------------------
  logic signed [TW:0] t_val [LANES];
  logic signed [TW:0] te_c, tl_c;
  logic               par_bad, vis_c;

  for (genvar l = 0; l < LANES; l++) begin : g_tval
    logic [TW-1:0] tmag;
    logic          neg;
    assign tmag = (edge_side_out.sat[l] || (ediv_q[l] > T_SAT)) ? T_SAT : ediv_q[l];
    assign neg  = edge_side_out.qneg[l] ^ edge_side_out.pneg[l];
    // A negative t only matters as "below zero", so it collapses to -1.
    assign t_val[l] = (neg && (tmag != '0)) ? '1 : {1'b0, tmag};
  end

  always_comb begin
    te_c    = '0;
    tl_c    = {1'b0, T_ONE};
    par_bad = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (edge_side_out.pzero[l]) begin
        par_bad = par_bad | edge_side_out.qneg[l];
      end else if (edge_side_out.pneg[l]) begin
        if (t_val[l] > te_c) te_c = t_val[l];
      end else begin
        if (t_val[l] < tl_c) tl_c = t_val[l];
      end
    end
    vis_c = !par_bad && (te_c <= tl_c);
  end

  logic            t_v_q, t_vis_q;
  coord_t          t_x0_q, t_y0_q;
  diff_t           t_dx_q, t_dy_q;
  logic [TE_W-1:0] t_te_q, t_tl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
    end else if (en) begin
      t_v_q <= ediv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_vis_q <= vis_c;
      t_x0_q  <= edge_side_out.x0;
      t_y0_q  <= edge_side_out.y0;
      t_dx_q  <= edge_side_out.dx;
      t_dy_q  <= edge_side_out.dy;
      t_te_q  <= te_c[TE_W-1:0];
      t_tl_q  <= tl_c[TE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage M1: the four t * |d| products, in result order: start x, start y,
  // end x, end y. On a visible segment te and tl lie in [0, 1].
  // ---------------------------------------------------------------------
  umag_t adx, ady;
  assign adx = magn(t_dx_q);
  assign ady = magn(t_dy_q);

  logic              m1_v_q, m1_vis_q, m1_dxn_q, m1_dyn_q;
  coord_t            m1_x0_q, m1_y0_q;
  logic [PROD_W-1:0] m1_prod_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= t_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_vis_q     <= t_vis_q;
      m1_dxn_q     <= t_dx_q[DIFF_W-1];
      m1_dyn_q     <= t_dy_q[DIFF_W-1];
      m1_x0_q      <= t_x0_q;
      m1_y0_q      <= t_y0_q;
      m1_prod_q[0] <= PROD_W'(t_te_q) * PROD_W'(adx);
      m1_prod_q[1] <= PROD_W'(t_te_q) * PROD_W'(ady);
      m1_prod_q[2] <= PROD_W'(t_tl_q) * PROD_W'(adx);
      m1_prod_q[3] <= PROD_W'(t_tl_q) * PROD_W'(ady);
    end
  end

  // ---------------------------------------------------------------------
  // Stage M2: clipped endpoints, start + trunc0(t * d). Truncation toward
  // zero falls out of working on the magnitude and applying the sign after.
  // The clipped point lies between the endpoints, so it fits CW bits.
  // ---------------------------------------------------------------------
  logic   m2_v_q, m2_vis_q;
  coord_t m2_c_q [LANES];
  coord_t clip_c [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_clip
    logic [CW+1:0]        off;
    logic signed [CW+1:0] base, sum;
    logic                 neg;
    assign off  = m1_prod_q[l][PROD_W-1:TF];
    assign neg  = (l % 2 == 0) ? m1_dxn_q : m1_dyn_q;
    assign base = (l % 2 == 0) ? {{2{m1_x0_q[CW-1]}}, m1_x0_q}
                               : {{2{m1_y0_q[CW-1]}}, m1_y0_q};
    assign sum  = neg ? (base - $signed(off)) : (base + $signed(off));
    assign clip_c[l] = sum[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (en) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_vis_q <= m1_vis_q;
      m2_c_q   <= clip_c;
    end
  end

  // ---------------------------------------------------------------------
  // Stage M3: mapping numerator |c - wmin| * |vmax - vmin| with the sign of
  // the whole quotient, including the sign of the window span.
  // ---------------------------------------------------------------------
  logic             m3_v_q, m3_vis_q;
  logic [NUM_W-1:0] m3_num_q [LANES];
  logic [3:0]       m3_neg_q;
  logic [NUM_W-1:0] num_c [LANES];
  logic [3:0]       neg_c;

  for (genvar l = 0; l < LANES; l++) begin : g_num
    diff_t a, s, d;
    assign a = widen(m2_c_q[l]) - ((l % 2 == 0) ? widen(win_x_min) : widen(win_y_min));
    assign s = (l % 2 == 0) ? view_dx : view_dy;
    assign d = (l % 2 == 0) ? win_dx : win_dy;
    assign num_c[l] = NUM_W'(magn(a)) * NUM_W'(magn(s));
    assign neg_c[l] = a[DIFF_W-1] ^ s[DIFF_W-1] ^ d[DIFF_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_v_q <= 1'b0;
    end else if (en) begin
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_vis_q <= m2_vis_q;
      m3_num_q <= num_c;
      m3_neg_q <= neg_c;
    end
  end

  // Mapping divider setup: divide by |wmax - wmin|, resolving CW+1 bits.
  logic [LANES-1:0][DIFF_W-1:0] mdiv_rem, mdiv_den;
  logic [LANES-1:0][MAP_QB-1:0] mdiv_acc, mdiv_q;
  map_side_t                    map_side_in, map_side_out;
  logic                         mdiv_v;

  for (genvar l = 0; l < LANES; l++) begin : g_map_setup
    umag_t dm;
    assign dm = (l % 2 == 0) ? magn(win_dx) : magn(win_dy);
    assign mdiv_rem[l] = m3_num_q[l][NUM_W-1:MAP_QB];
    assign mdiv_den[l] = dm;
    assign mdiv_acc[l] = m3_num_q[l][MAP_QB-1:0];
    assign map_side_in.sat[l] = m3_num_q[l][NUM_W-1:MAP_QB] >= dm;
  end

  assign map_side_in.visible = m3_vis_q;
  assign map_side_in.neg     = m3_neg_q;

  lcvm_div_chain #(
    .LANES(LANES),
    .DW   (DIFF_W),
    .QB   (MAP_QB),
    .SW   ($bits(map_side_t))
  ) u_map_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(m3_v_q),
    .rem_i  (mdiv_rem),
    .den_i  (mdiv_den),
    .acc_i  (mdiv_acc),
    .side_i (map_side_in),
    .valid_o(mdiv_v),
    .acc_o  (mdiv_q),
    .side_o (map_side_out)
  );

  // ---------------------------------------------------------------------
  // Final: vmin + signed quotient, saturated to CW bits. A window of zero
  // width on an axis maps everything on that axis to view min. A rejected
  // segment reports zeros.
  // ---------------------------------------------------------------------
  coord_t  map_c [LANES];
  result_t res_c;

  for (genvar l = 0; l < LANES; l++) begin : g_final
    logic signed [CW+2:0] vmin_w, qv, sum;
    logic                 dzero;
    coord_t               vmin;
    assign vmin   = (l % 2 == 0) ? view_x_min : view_y_min;
    assign dzero  = (l % 2 == 0) ? (win_dx == '0) : (win_dy == '0);
    assign vmin_w = {{3{vmin[CW-1]}}, vmin};
    assign qv     = $signed({2'b00, mdiv_q[l]});
    assign sum    = map_side_out.neg[l] ? (vmin_w - qv) : (vmin_w + qv);
    always_comb begin
      if (!map_side_out.visible) begin
        map_c[l] = '0;
      end else if (dzero) begin
        map_c[l] = vmin;
      end else if (map_side_out.sat[l]) begin
        map_c[l] = map_side_out.neg[l] ? V_MIN[CW-1:0] : V_MAX[CW-1:0];
      end else if (sum > V_MAX) begin
        map_c[l] = V_MAX[CW-1:0];
      end else if (sum < V_MIN) begin
        map_c[l] = V_MIN[CW-1:0];
      end else begin
        map_c[l] = sum[CW-1:0];
      end
    end
  end

  assign res_c.visible = map_side_out.visible;
  assign res_c.sx      = map_c[0];
  assign res_c.sy      = map_c[1];
  assign res_c.ex      = map_c[2];
  assign res_c.ey      = map_c[3];

  // ---------------------------------------------------------------------
  // Output register with skid. A result leaves the last cell whenever the
  // pipeline advances; it goes to the output register if that is free or
  // being emptied, else to the skid register, which then stalls the pipe.
  // ---------------------------------------------------------------------
  logic push;
  assign push = en && mdiv_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : res_c;
    end else if (push) begin
      skid_q <= res_c;
    end
  end

  assign out_valid_o   = out_v_q;
  assign visible_o     = out_q.visible;
  assign out_start_x_o = out_q.sx;
  assign out_start_y_o = out_q.sy;
  assign out_end_x_o   = out_q.ex;
  assign out_end_y_o   = out_q.ey;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // The skid register only ever backs a held output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output is empty");

  // The skid register fills only when the output was stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid register filled without an output stall");

  // A rejected segment reports all-zero coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.visible) |->
      (out_q.sx == '0 && out_q.sy == '0 && out_q.ex == '0 && out_q.ey == '0))
    else $error("rejected segment carries nonzero coordinates");

endmodule

/* test/line_clip_viewport_map_unit_tb.sv */
module line_clip_viewport_map_unit_tb;

  localparam int unsigned CW         = 16;
  localparam longint      T_ONE      = 64'sd65536;
  localparam int unsigned LATENCY    = 40;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned HOLD_LEN   = 400;

  // One result record: the visible flag and the four mapped coordinates.
  typedef struct packed {
    logic                 visible;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } seg_result_t;

  // The scoreboard keeps the predicted results in arrival order and compares
  // each result that leaves the block with the oldest prediction.
  class clip_scoreboard;
    seg_result_t pending[$];
    int          errors = 0;

    function void note_request(seg_result_t predicted);
      pending.push_back(predicted);
    endfunction

    function void check_result(seg_result_t got);
      seg_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.visible !== want.visible) begin
        $display("%0t: visible expected %0d actual %0d", $time, want.visible, got.visible);
        errors++;
      end
      if (got.sx !== want.sx) begin
        $display("%0t: out_start_x expected %0d actual %0d", $time, want.sx, got.sx);
        errors++;
      end
      if (got.sy !== want.sy) begin
        $display("%0t: out_start_y expected %0d actual %0d", $time, want.sy, got.sy);
        errors++;
      end
      if (got.ex !== want.ex) begin
        $display("%0t: out_end_x expected %0d actual %0d", $time, want.ex, got.ex);
        errors++;
      end
      if (got.ey !== want.ey) begin
        $display("%0t: out_end_y expected %0d actual %0d", $time, want.ey, got.ey);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel, penable, pwrite;
  logic [lcvm_pkg::APB_ADDR_W-1:0] paddr;
  logic [lcvm_pkg::APB_DATA_W-1:0] pwdata;
  logic [lcvm_pkg::APB_DATA_W-1:0] prdata;
  logic                 pready;
  logic                 in_valid_i, in_ready_o;
  logic signed [CW-1:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic                 out_valid_o, out_ready_i, visible_o;
  logic signed [CW-1:0] out_start_x_o, out_start_y_o, out_end_x_o, out_end_y_o;

  line_clip_viewport_map_unit i_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .out_valid_o, .out_ready_i, .visible_o,
    .out_start_x_o, .out_start_y_o, .out_end_x_o, .out_end_y_o
  );

  clip_scoreboard sb = new();

  // Shadow copy of the window and viewport registers, sign extended.
  longint cfg_shadow [lcvm_pkg::NUM_REGS];
  bit     hold_off_req = 0;
  bit     timed_out    = 0;
  int     idle_cycles  = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------------

  function automatic longint clamp_coord(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // One edge test of the clipper. A zero p means the segment runs parallel to
  // the edge: it survives only when it lies on the inner side. Otherwise the
  // crossing parameter moves the entry or exit bound, and the segment dies as
  // soon as the entry would pass the exit. SV signed division truncates toward
  // zero, which is what the hardware does.
  function automatic bit edge_pass(longint p, longint q, inout longint t_in,
                                   inout longint t_out);
    longint t;
    if (p == 0) return q >= 0;
    t = (q * T_ONE) / p;
    if (p < 0) begin
      if (t > t_in) t_in = t;
      if (t > t_out) return 0;
    end else begin
      if (t < t_out) t_out = t;
      if (t < t_in) return 0;
    end
    return 1;
  endfunction

  // Linear window to viewport map with saturation. A collapsed window axis
  // maps everything to the viewport minimum.
  function automatic longint map_axis(longint c, longint wmin, longint wmax,
                                      longint vmin, longint vmax);
    longint span;
    span = wmax - wmin;
    if (span == 0) return clamp_coord(vmin);
    return clamp_coord(vmin + ((c - wmin) * (vmax - vmin)) / span);
  endfunction

  function automatic seg_result_t clip_and_map(longint x0, longint y0,
                                               longint x1, longint y1);
    seg_result_t r;
    longint dx, dy, t_in, t_out, cx0, cy0, cx1, cy1;
    r = '0;
    dx = x1 - x0;
    dy = y1 - y0;
    t_in = 0;
    t_out = T_ONE;
    if (!edge_pass(-dx, x0 - cfg_shadow[lcvm_pkg::REG_WIN_X_MIN], t_in, t_out)) return r;
    if (!edge_pass(dx, cfg_shadow[lcvm_pkg::REG_WIN_X_MAX] - x0, t_in, t_out)) return r;
    if (!edge_pass(-dy, y0 - cfg_shadow[lcvm_pkg::REG_WIN_Y_MIN], t_in, t_out)) return r;
    if (!edge_pass(dy, cfg_shadow[lcvm_pkg::REG_WIN_Y_MAX] - y0, t_in, t_out)) return r;
    cx0 = x0; cy0 = y0; cx1 = x1; cy1 = y1;
    if (t_out < T_ONE) begin
      cx1 = x0 + (t_out * dx) / T_ONE;
      cy1 = y0 + (t_out * dy) / T_ONE;
    end
    if (t_in > 0) begin
      cx0 = x0 + (t_in * dx) / T_ONE;
      cy0 = y0 + (t_in * dy) / T_ONE;
    end
    r.visible = 1'b1;
    r.sx = CW'(map_axis(cx0, cfg_shadow[lcvm_pkg::REG_WIN_X_MIN],
                        cfg_shadow[lcvm_pkg::REG_WIN_X_MAX],
                        cfg_shadow[lcvm_pkg::REG_VIEW_X_MIN],
                        cfg_shadow[lcvm_pkg::REG_VIEW_X_MAX]));
    r.sy = CW'(map_axis(cy0, cfg_shadow[lcvm_pkg::REG_WIN_Y_MIN],
                        cfg_shadow[lcvm_pkg::REG_WIN_Y_MAX],
                        cfg_shadow[lcvm_pkg::REG_VIEW_Y_MIN],
                        cfg_shadow[lcvm_pkg::REG_VIEW_Y_MAX]));
    r.ex = CW'(map_axis(cx1, cfg_shadow[lcvm_pkg::REG_WIN_X_MIN],
                        cfg_shadow[lcvm_pkg::REG_WIN_X_MAX],
                        cfg_shadow[lcvm_pkg::REG_VIEW_X_MIN],
                        cfg_shadow[lcvm_pkg::REG_VIEW_X_MAX]));
    r.ey = CW'(map_axis(cy1, cfg_shadow[lcvm_pkg::REG_WIN_Y_MIN],
                        cfg_shadow[lcvm_pkg::REG_WIN_Y_MAX],
                        cfg_shadow[lcvm_pkg::REG_VIEW_Y_MIN],
                        cfg_shadow[lcvm_pkg::REG_VIEW_Y_MAX]));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------

  // APB write: a setup cycle, then an access cycle. The register takes the
  // value at the rising edge of the access cycle, since pready is always high.
  // Only the low coordinate bits are kept, so the upper data bits get random
  // junk to show that they are ignored.
  task automatic write_reg(lcvm_pkg::cfg_reg_e idx, logic signed [CW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {16'($urandom), value};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    cfg_shadow[idx] = longint'(value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_window(int wx0, int wy0, int wx1, int wy1,
                              int vx0, int vy0, int vx1, int vy1);
    write_reg(lcvm_pkg::REG_WIN_X_MIN, wx0[CW-1:0]);
    write_reg(lcvm_pkg::REG_WIN_Y_MIN, wy0[CW-1:0]);
    write_reg(lcvm_pkg::REG_WIN_X_MAX, wx1[CW-1:0]);
    write_reg(lcvm_pkg::REG_WIN_Y_MAX, wy1[CW-1:0]);
    write_reg(lcvm_pkg::REG_VIEW_X_MIN, vx0[CW-1:0]);
    write_reg(lcvm_pkg::REG_VIEW_Y_MIN, vy0[CW-1:0]);
    write_reg(lcvm_pkg::REG_VIEW_X_MAX, vx1[CW-1:0]);
    write_reg(lcvm_pkg::REG_VIEW_Y_MAX, vy1[CW-1:0]);
  endtask

  // Offer one segment and wait for it to be taken. Valid is left high, so a
  // following call in the next cycle forms a back-to-back burst.
  task automatic send_segment(int x0, int y0, int x1, int y1);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    start_x_i  = x0[CW-1:0];
    start_y_i  = y0[CW-1:0];
    end_x_i    = x1[CW-1:0];
    end_y_i    = y1[CW-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(clip_and_map(longint'(start_x_i), longint'(start_y_i),
                                 longint'(end_x_i), longint'(end_y_i)));
  endtask

  // Pick a coordinate around the window span on one axis, half a span plus 16
  // out on either side, so that most segments cross an edge.
  function automatic int near_window(longint a, longint b);
    longint lo, hi, margin;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    margin = (hi - lo) / 2 + 16;
    lo = clamp_coord(lo - margin);
    hi = clamp_coord(hi + margin);
    return int'(lo) + int'($urandom_range(0, int'(hi - lo)));
  endfunction

  // Random traffic in bursts with random gaps. Most segments live near the
  // window; the rest span the full coordinate range.
  task automatic random_segments(int count);
    int burst, x0, y0, x1, y1;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        x0 = near_window(cfg_shadow[lcvm_pkg::REG_WIN_X_MIN],
                         cfg_shadow[lcvm_pkg::REG_WIN_X_MAX]);
        x1 = near_window(cfg_shadow[lcvm_pkg::REG_WIN_X_MIN],
                         cfg_shadow[lcvm_pkg::REG_WIN_X_MAX]);
        y0 = near_window(cfg_shadow[lcvm_pkg::REG_WIN_Y_MIN],
                         cfg_shadow[lcvm_pkg::REG_WIN_Y_MAX]);
        y1 = near_window(cfg_shadow[lcvm_pkg::REG_WIN_Y_MIN],
                         cfg_shadow[lcvm_pkg::REG_WIN_Y_MAX]);
        // Some axis-parallel segments to hit the parallel edge test.
        if ($urandom_range(0, 9) == 0) y1 = y0;
        else if ($urandom_range(0, 9) == 0) x1 = x0;
      end else begin
        x0 = int'($signed(16'($urandom)));
        y0 = int'($signed(16'($urandom)));
        x1 = int'($signed(16'($urandom)));
        y1 = int'($signed(16'($urandom)));
      end
      send_segment(x0, y0, x1, y1);
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 3) != 0) begin
          @(negedge clk_i);
          in_valid_i = 1'b0;
          repeat ($urandom_range(0, 8)) @(negedge clk_i);
        end
      end else begin
        burst--;
      end
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls on its own pattern, switching between runs to a random
  // style: always ready, coin flips or mostly stalled. A hold-off request
  // parks it for a long stretch so that the pipeline fills up.
  // ---------------------------------------------------------------------------
  initial begin
    int style;
    out_ready_i = 1'b0;
    forever begin
      if (hold_off_req) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
        hold_off_req = 0;
      end
      style = $urandom_range(0, 2);
      repeat (100) begin
        @(negedge clk_i);
        case (style)
          0: out_ready_i = 1'b1;
          1: out_ready_i = $urandom_range(0, 1);
          default: out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Result monitor and watchdog, both on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({visible_o, out_start_x_o, out_start_y_o, out_end_x_o,
                       out_end_y_o});
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    timed_out = 1;
    $display("line_clip_viewport_map_unit_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid_i = 0;
    start_x_i = '0; start_y_i = '0; end_x_i = '0; end_y_i = '0;
    for (int i = 0; i < lcvm_pkg::NUM_REGS; i++)
      cfg_shadow[i] = longint'(lcvm_pkg::CFG_RESET[i]);
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed segments against the reset window [800,1600] squared.
    send_segment(1000, 1000, 1400, 1400);     // fully inside
    send_segment(0, 1200, 3000, 1200);        // horizontal, crosses both sides
    send_segment(0, 0, 500, 500);             // outside, rejected
    send_segment(0, 2000, 3000, 2000);        // parallel outside on top
    send_segment(1200, 0, 1200, 3000);        // vertical through
    send_segment(500, 1200, 500, 1400);       // parallel outside on left
    send_segment(1200, 1200, 1200, 1200);     // a single point inside
    send_segment(100, 100, 100, 100);         // a single point outside
    send_segment(0, 1700, 1700, 0);           // diagonal cutting across the window corner
    send_segment(0, 1600, 1600, 0);           // diagonal touching a corner
    send_segment(2400, 2400, 0, 0);           // reversed diagonal
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, 32767, -32768, -32768);
    send_segment(-32768, 32767, 32767, -32768);
    send_segment(-32768, -32768, -32768, -32768);
    send_segment(32767, 32767, 32767, 32767);
    send_segment(800, 800, 1600, 1600);       // on the window edges exactly
    @(negedge clk_i);
    in_valid_i = 1'b0;

    // Reset configuration with random traffic and one long receiver hold-off.
    hold_off_req = 1;
    random_segments(200);
    drain();

    // Ordinary window and viewport.
    write_window(-4000, -2000, 6000, 3000, 100, 200, 9000, 7000);
    random_segments(200);
    drain();

    // Full-range window and viewport.
    write_window(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    random_segments(180);
    drain();

    // Small window mapped onto a huge viewport: the mapping saturates.
    write_window(-16, -16, 16, 16, -32768, 32767, 32767, -32768);
    random_segments(180);
    drain();

    // Collapsed window axes.
    write_window(500, -300, 500, 700, 0, 0, 4000, 4000);
    random_segments(120);
    drain();
    write_window(-300, 500, 700, 500, -1000, -1000, 1000, 1000);
    random_segments(120);
    drain();

    // Inverted window and viewport.
    write_window(2000, 1500, -2000, -1500, 8000, -8000, -8000, 8000);
    random_segments(150);
    drain();

    // Fully random registers.
    write_window(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                 int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                 int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                 int'($signed(16'($urandom))), int'($signed(16'($urandom))));
    random_segments(150);
    drain();

    repeat (LATENCY + 20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("line_clip_viewport_map_unit_tb: done, clean");
    else
      $display("line_clip_viewport_map_unit_tb: done, errors");
    $finish;
  end

endmodule
